[hdl/deq_pkg.sv]
// Shared constants for the double-ended queue: request codes, status codes
// and the fixed field widths. No dependencies.
package deq_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DATA_W   = 32;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LIST       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

[hdl/deq_ram.sv]
// Ring storage of the double-ended queue: one write port and one read port
// with registered read data. Depends on nothing but its parameters.
module deq_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit values. A transaction is taken
// when start is high and busy is low. Push requests and every full or empty
// answer are done in the next cycle, and the next transaction may follow at once. A
// successful pop goes through the registered read data of the ring memory
// and the S_POP state, with busy high, before its result. A list request makes
// one memory read per entry, issued back to back, with each entry shown for
// one cycle on the result ports. Results are marked by result_valid_o for
// exactly one cycle and cannot be held off.
// Request codes five to seven are dropped without a result.
// Depends on deq_pkg and deq_ram.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [REQ_W-1:0]           req_type_i,
  input  logic signed [DATA_W-1:0]   value_i,
  output logic                       result_valid_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [DATA_W-1:0]   item_o,
  output logic                       last_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W:0] CAP_EXT = (IDX_W + 1)'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;

  // Modular add of two ring indexes, both below CAPACITY.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CAP_EXT) begin
      s = s - CAP_EXT;
    end
    return s[IDX_W-1:0];
  endfunction

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;

  logic                valid_q, valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [DATA_W-1:0]   item_q, item_d;
  logic                last_q, last_d;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;

  logic             full, empty, list_last;
  logic [IDX_W-1:0] front_inc, front_dec, back_wr, back_rd;

  assign full      = (occ_q == CNT_W'(CAPACITY));
  assign empty     = (occ_q == '0);
  assign front_inc = ring_add(front_q, IDX_W'(1));
  assign front_dec = ring_add(front_q, IDX_W'(CAPACITY - 1));
  assign back_wr   = ring_add(front_q, occ_q[IDX_W-1:0]);
  assign back_rd   = ring_add(front_q, IDX_W'(occ_q - CNT_W'(1)));
  assign list_last = ((CNT_W'(cnt_q) + CNT_W'(1)) == occ_q);

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    occ_d    = occ_q;
    cnt_d    = cnt_q;
    valid_d  = 1'b0;
    status_d = ST_OK;
    item_d   = '0;
    last_d   = 1'b1;
    we       = 1'b0;
    waddr    = back_wr;
    re       = 1'b0;
    raddr    = front_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (req_type_i)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              valid_d = 1'b1;
              if (full) begin
                status_d = ST_FULL;
              end else begin
                we    = 1'b1;
                occ_d = occ_q + CNT_W'(1);
                if (req_type_i == REQ_PUSH_FRONT) begin
                  waddr   = front_dec;
                  front_d = front_dec;
                end
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (empty) begin
                valid_d  = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                re      = 1'b1;
                occ_d   = occ_q - CNT_W'(1);
                state_d = S_POP;
                if (req_type_i == REQ_POP_FRONT) begin
                  front_d = front_inc;
                end else begin
                  raddr = back_rd;
                end
              end
            end
            REQ_LIST: begin
              if (empty) begin
                valid_d  = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                re      = 1'b1;
                cnt_d   = '0;
                state_d = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        valid_d = 1'b1;
        item_d  = rdata;
        state_d = S_IDLE;
      end
      S_LIST: begin
        // The read for entry cnt_q has returned; fetch the next one while
        // this one goes out.
        valid_d = 1'b1;
        item_d  = rdata;
        last_d  = list_last;
        if (list_last) begin
          state_d = S_IDLE;
        end else begin
          re    = 1'b1;
          raddr = ring_add(front_q, cnt_q + IDX_W'(1));
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      occ_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      occ_q   <= occ_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    item_q   <= item_d;
    last_q   <= last_d;
  end

  deq_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign item_o         = item_q;
  assign last_o         = last_q;

endmodule

[hdl/deq_checker.sv]
// Port-level checks for the double-ended queue, attached to the top level
// by the bind statement at the end. Depends on deq_pkg.
module deq_checker
  import deq_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic [REQ_W-1:0]         req_type_i,
  input logic                     result_valid_o,
  input logic [STATUS_W-1:0]      status_o,
  input logic signed [DATA_W-1:0] item_o,
  input logic                     last_o
);

  logic take;
  assign take = start && !busy;

  // A push transaction is answered in the very next cycle with a single result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (req_type_i == REQ_PUSH_FRONT || req_type_i == REQ_PUSH_BACK)
    |=> result_valid_o && last_o && item_o == '0 && !busy)
    else $error("push transaction not answered next cycle");

  // A pop either answers empty at once or starts a memory read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (req_type_i == REQ_POP_FRONT || req_type_i == REQ_POP_BACK)
    |=> (result_valid_o && status_o == ST_EMPTY && !busy) || (busy && !result_valid_o))
    else $error("pop transaction took an unexpected path");

  // Unknown request codes leave no trace.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && req_type_i != REQ_PUSH_FRONT && req_type_i != REQ_PUSH_BACK &&
    req_type_i != REQ_POP_FRONT && req_type_i != REQ_POP_BACK && req_type_i != REQ_LIST
    |=> !result_valid_o && !busy)
    else $error("unknown request produced activity");

  // A full or empty answer is always a single result with a zero item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_OK |-> last_o && item_o == '0)
    else $error("error result with item or continuation");

  // A list result that is not the last keeps the block busy for the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy && status_o == ST_OK ##1 result_valid_o)
    else $error("list sequence broken");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
